/* rtl/speck_keyed_byte_hash_core_defines.svh */
// Assertion macros for the checker module of the keyed byte hash core.
`ifndef SPECK_KEYED_BYTE_HASH_CORE_DEFINES_SVH
`define SPECK_KEYED_BYTE_HASH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKBH_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SKBH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/skbh_pkg.sv */
// Package with the shared types and constants of the keyed byte hash core.
package skbh_pkg;

   // Field and word widths.
   localparam int WORD_W   = 64;
   localparam int BYTE_W   = 8;
   localparam int FOLD_W   = 32;
   localparam int COUNT_W  = 4;
   localparam int BLOCK_BYTES = 16;
   localparam int CSR_ADDR_W  = 1;

   // Default number of cipher rounds per block.
   localparam int SKBH_ROUNDS = 32;

   // Rotation amounts of the round function.
   localparam int ROT_RIGHT = 8;
   localparam int ROT_LEFT  = 3;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LOW  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_HIGH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // take the accepted transaction into the block buffer
      logic start;     // load the cipher registers and the key schedule
      logic round_en;  // run one cipher round
      logic emit;      // move the accumulator to the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic block_done;  // this byte completes a 16-byte block
      logic pad_needed;  // bytes are held after this transaction
      logic round_last;  // the current round is the final one
      logic out_free;    // the result register can take a new hash
   } status_type;

endpackage

/* rtl/skbh_datapath.sv */
// Datapath of the keyed byte hash core: block buffer, cipher rounds, accumulator and result.
module skbh_datapath #(
   parameter int ROUNDS = skbh_pkg::SKBH_ROUNDS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  skbh_pkg::cmd_type                   cmd,
   output skbh_pkg::status_type                status,
   input  logic [skbh_pkg::BYTE_W-1:0]         data_byte,
   input  logic                                has_byte,
   input  logic                                last_byte,
   input  logic                                csr_we,
   input  logic [skbh_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [skbh_pkg::WORD_W-1:0]         csr_wdata,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [skbh_pkg::WORD_W-1:0]         hash_wide,
   output logic [skbh_pkg::FOLD_W-1:0]         hash_narrow
);
   import skbh_pkg::*;

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int BLOCK_W = 2 * WORD_W;

   logic [WORD_W-1:0]  key_low_ff, key_high_ff;
   logic [BLOCK_W-1:0] blk_ff, blk_merge;
   logic [COUNT_W-1:0] cnt_ff, cnt_next;
   logic [WORD_W-1:0]  acc_ff;
   logic [WORD_W-1:0]  c0_ff, c1_ff, s0_ff, s1_ff;
   logic [WORD_W-1:0]  x_in, y_in, a_in, b_in;
   logic [RW-1:0]      rnd_ff;
   logic               out_valid_ff;
   logic [WORD_W-1:0]  out_wide_ff;
   logic [FOLD_W-1:0]  out_narrow_ff;

   // Key registers, written by the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Place the incoming byte at the current fill position.
   always_comb begin
      blk_merge = blk_ff;
      if (has_byte) begin
         for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (cnt_ff == COUNT_W'(k)) begin
               blk_merge[k*BYTE_W +: BYTE_W] = data_byte;
            end
         end
      end
   end

   assign cnt_next = has_byte ? cnt_ff + 1'b1 : cnt_ff;

   // One cipher round and one key schedule step.
   always_comb begin
      x_in = ({c1_ff[ROT_RIGHT-1:0], c1_ff[WORD_W-1:ROT_RIGHT]} + c0_ff) ^ s0_ff;
      y_in = {c0_ff[WORD_W-ROT_LEFT-1:0], c0_ff[WORD_W-1:WORD_W-ROT_LEFT]} ^ x_in;
      b_in = ({s1_ff[ROT_RIGHT-1:0], s1_ff[WORD_W-1:ROT_RIGHT]} + s0_ff)
             ^ {{(WORD_W-RW){1'b0}}, rnd_ff};
      a_in = {s0_ff[WORD_W-ROT_LEFT-1:0], s0_ff[WORD_W-1:WORD_W-ROT_LEFT]} ^ b_in;
   end

   // Status toward the controller.
   always_comb begin
      status.block_done = has_byte && (cnt_ff == {COUNT_W{1'b1}});
      status.pad_needed = (cnt_next != '0);
      status.round_last = (rnd_ff == RW'(ROUNDS - 1));
      status.out_free   = !out_valid_ff || out_ready;
   end

   // Block buffer and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         blk_ff <= (cmd.start || last_byte) ? '0 : blk_merge;
         cnt_ff <= last_byte ? '0 : cnt_next;
      end
   end

   // Cipher working registers and round counter.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         c0_ff  <= blk_merge[WORD_W-1:0];
         c1_ff  <= blk_merge[BLOCK_W-1:WORD_W];
         s0_ff  <= key_low_ff;
         s1_ff  <= key_high_ff;
         rnd_ff <= '0;
      end else if (cmd.round_en) begin
         c0_ff  <= y_in;
         c1_ff  <= x_in;
         s0_ff  <= a_in;
         s1_ff  <= b_in;
         rnd_ff <= rnd_ff + 1'b1;
      end
   end

   // Accumulator: folds each finished block in, cleared when the hash leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.emit) begin
         acc_ff <= '0;
      end else if (cmd.round_en && status.round_last) begin
         acc_ff <= acc_ff ^ x_in ^ y_in;
      end
   end

   // Result register, held until the downstream side takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_wide_ff   <= acc_ff;
         out_narrow_ff <= acc_ff[WORD_W-1:FOLD_W] ^ acc_ff[FOLD_W-1:0];
      end
   end

   assign out_valid   = out_valid_ff;
   assign hash_wide   = out_wide_ff;
   assign hash_narrow = out_narrow_ff;

endmodule

/* rtl/skbh_ctrl.sv */
// Controller state machine of the keyed byte hash core.
module skbh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 last_byte,
   output logic                 req_ready,
   input  skbh_pkg::status_type status,
   output skbh_pkg::cmd_type    cmd
);
   import skbh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      cmd.load     = 1'b0;
      cmd.start    = 1'b0;
      cmd.round_en = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               last_in  = last_byte;
               if (status.block_done || (last_byte && status.pad_needed)) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ROUND;
               end else if (last_byte) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (status.round_last) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and the pending end-of-message flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

/* rtl/speck_keyed_byte_hash_core.sv */
// Keyed 64-bit byte-stream hash built on Speck128/128, at most one byte per transaction.
// The 16th byte of a block, or a transaction with tlast set while bytes are
// held, starts the cipher, which runs one round per cycle in a single shared
// round unit, so the block takes no next transaction until the final round.
// A tlast transaction then loads the result register, waiting for rsp_tready
// while an earlier hash is still held there. Each enciphered block is XORed
// into a 64-bit accumulator; the hash and its 32-bit fold leave on the rsp
// channel and the accumulator restarts from zero. The key is written through
// the csr port (index 0 low word, index 1 high word); the user must write it
// only while the block is idle, which the block itself does not enforce.
module speck_keyed_byte_hash_core #(
   parameter int ROUNDS = skbh_pkg::SKBH_ROUNDS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Input channel.
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [skbh_pkg::BYTE_W-1:0]               req_tdata,  // [7:0] data_byte
   input  logic                                      req_tuser,  // [0] has_byte
   input  logic                                      req_tlast,  // last_byte
   // Result channel.
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // [63:0] hash_wide, [95:64] hash_narrow
   output logic [skbh_pkg::WORD_W+skbh_pkg::FOLD_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic                                      csr_we,
   input  logic [skbh_pkg::CSR_ADDR_W-1:0]           csr_addr,
   input  logic [skbh_pkg::WORD_W-1:0]               csr_wdata
);
   import skbh_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [WORD_W-1:0] hash_wide;
   logic [FOLD_W-1:0] hash_narrow;

   // Sequencing of load, rounds and result.
   skbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .last_byte (req_tlast),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Buffer, cipher and accumulator.
   skbh_datapath #(
      .ROUNDS (ROUNDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .data_byte   (req_tdata),
      .has_byte    (req_tuser),
      .last_byte   (req_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .hash_wide   (hash_wide),
      .hash_narrow (hash_narrow)
   );

   assign rsp_tdata = {hash_narrow, hash_wide};

endmodule

/* rtl/skbh_checker.sv */
// Port-level checker of the keyed byte hash core and its bind statement.
`include "speck_keyed_byte_hash_core_defines.svh"

module skbh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // A stalled result transaction keeps its valid and its data.
   `SKBH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // The narrow hash is always the fold of the wide hash.
   `SKBH_ASSERT_SAME(a_fold, clock, reset, rsp_tvalid, rsp_tdata[95:64] == (rsp_tdata[63:32] ^ rsp_tdata[31:0]), "hash_narrow is not the fold of hash_wide")

   // An end-of-message transaction always makes the input side busy in the next cycle.
   `SKBH_ASSERT_NEXT(a_last_busy, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input ready right after an end of message")

   // A transaction with no byte and no end leaves the block ready.
   `SKBH_ASSERT_NEXT(a_noop_ready, clock, reset, req_tvalid && req_tready && !req_tuser && !req_tlast, req_tready, "empty transaction made the block busy")

endmodule

bind speck_keyed_byte_hash_core skbh_checker u_skbh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
